>>> design/cbm_pkg.sv
// -----------------------------------------------------------------------------
// Cartridge bank mapper package
// Types and decode constants shared by the mapper modules and the testbench.
// -----------------------------------------------------------------------------
`default_nettype none

package cbm_pkg;

   typedef enum logic [1:0] {
      ACT_NONE   = 2'd0,
      ACT_PRG    = 2'd1,
      ACT_CHR    = 2'd2,
      ACT_MIRROR = 2'd3
   } cbm_action_type;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_TICK  = 1'b1
   } cbm_command_type;

   typedef struct packed {
      cbm_action_type action;
      logic           prg_window;
      logic [7:0]     prg_bank;
      logic [2:0]     chr_slot;
      logic [11:0]    chr_page;
      logic           chr_is_ram;
      logic [1:0]     mirroring;
      logic           irq_pulse;
   } cbm_rsp_type;

   localparam logic [3:0]  TOP_PRG_LOW   = 4'h8;
   localparam logic [3:0]  TOP_PRG_HIGH  = 4'hA;
   localparam logic [3:0]  TOP_CHR_FIRST = 4'hB;
   localparam logic [3:0]  TOP_CHR_LAST  = 4'hE;

   localparam logic [15:0] DEC_MASK      = 16'hF00C;
   localparam logic [15:0] DEC_MIRROR    = 16'h9000;
   localparam logic [15:0] DEC_LATCH_LO  = 16'hF000;
   localparam logic [15:0] DEC_LATCH_HI  = 16'hF004;
   localparam logic [15:0] DEC_IRQ_CTRL  = 16'hF008;
   localparam logic [15:0] DEC_IRQ_ACK   = 16'hF00C;

   localparam logic [7:0]  COUNT_MAX     = 8'hFF;
   localparam logic [11:0] PAGE_RAM_LO   = 12'd4;
   localparam logic [11:0] PAGE_RAM_HI   = 12'd5;

endpackage

`default_nettype wire

>>> design/cbm_req_if.sv
// -----------------------------------------------------------------------------
// Mapper request channel
// Valid/ready channel carrying one bus write or scanline tick per beat.
// -----------------------------------------------------------------------------
`default_nettype none

interface cbm_req_if;
   logic        valid;
   logic        ready;
   logic        command;
   logic [15:0] address;
   logic [7:0]  value;

   modport source (output valid, output command, output address, output value,
                   input ready);
   modport sink   (input valid, input command, input address, input value,
                   output ready);
endinterface

`default_nettype wire

>>> design/cbm_rsp_if.sv
// -----------------------------------------------------------------------------
// Mapper response channel
// Valid/ready channel carrying one mapping event per beat.
// -----------------------------------------------------------------------------
`default_nettype none

interface cbm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic        prg_window;
   logic [7:0]  prg_bank;
   logic [2:0]  chr_slot;
   logic [11:0] chr_page;
   logic        chr_is_ram;
   logic [1:0]  mirroring;
   logic        irq_pulse;

   modport source (output valid, output action, output prg_window, output prg_bank,
                   output chr_slot, output chr_page, output chr_is_ram,
                   output mirroring, output irq_pulse, input ready);
   modport sink   (input valid, input action, input prg_window, input prg_bank,
                   input chr_slot, input chr_page, input chr_is_ram,
                   input mirroring, input irq_pulse, output ready);
endinterface

`default_nettype wire

>>> design/cbm_regs.sv
// -----------------------------------------------------------------------------
// Mapper register file and decode
// Decodes one beat, updates the bank and IRQ registers and forms the result.
// -----------------------------------------------------------------------------
`default_nettype none

module cbm_regs (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          strobe,
   input  wire logic          command,
   input  wire logic [15:0]   address,
   input  wire logic [7:0]    value,
   output cbm_pkg::cbm_rsp_type result
);
   import cbm_pkg::*;

   logic [7:0] chr_bank_ff [8];
   logic [7:0] chr_bank_in;
   logic       chr_we;
   logic [7:0] latch_ff, latch_in;
   logic [7:0] count_ff, count_in;
   logic       enabled_ff, enabled_in;
   logic       rearm_ff, rearm_in;

   logic [3:0]  top;
   logic [15:0] dec;
   logic [1:0]  slot_diff;
   logic [2:0]  slot;

   assign top       = address[15:12];
   assign dec       = address & DEC_MASK;
   assign slot_diff = 2'(top - TOP_CHR_FIRST);
   assign slot      = {slot_diff, address[3]};

   always_comb begin
      result      = '0;
      chr_bank_in = chr_bank_ff[slot];
      chr_we      = 1'b0;
      latch_in    = latch_ff;
      count_in    = count_ff;
      enabled_in  = enabled_ff;
      rearm_in    = rearm_ff;
      priority if (command == CMD_TICK) begin
         if (enabled_ff) begin
            if (count_ff == COUNT_MAX) begin
               count_in         = latch_ff;
               enabled_in       = rearm_ff;
               result.irq_pulse = 1'b1;
            end else begin
               count_in = count_ff + 8'd1;
            end
         end
      end else if (top == TOP_PRG_LOW || top == TOP_PRG_HIGH) begin
         result.action     = ACT_PRG;
         result.prg_window = (top == TOP_PRG_HIGH);
         result.prg_bank   = value;
      end else if (dec == DEC_MIRROR) begin
         result.action    = ACT_MIRROR;
         result.mirroring = value[1:0];
      end else if (top >= TOP_CHR_FIRST && top <= TOP_CHR_LAST) begin
         chr_we          = 1'b1;
         result.action   = ACT_CHR;
         result.chr_slot = slot;
         if (!address[2]) begin
            chr_bank_in     = {chr_bank_ff[slot][7:4], value[3:0]};
            result.chr_page = {4'd0, chr_bank_in};
         end else begin
            chr_bank_in     = {value[3:0], chr_bank_ff[slot][3:0]};
            result.chr_page = {value[7:4], chr_bank_in};
         end
         result.chr_is_ram = (result.chr_page == PAGE_RAM_LO) ||
                             (result.chr_page == PAGE_RAM_HI);
      end else begin
         unique case (dec)
            DEC_LATCH_LO: latch_in = {latch_ff[7:4], value[3:0]};
            DEC_LATCH_HI: latch_in = {value[3:0], latch_ff[3:0]};
            DEC_IRQ_CTRL: begin
               enabled_in = value[1];
               rearm_in   = value[0];
               count_in   = latch_ff;
            end
            DEC_IRQ_ACK:  enabled_in = rearm_ff;
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 8; i++) begin
            chr_bank_ff[i] <= '0;
         end
         latch_ff   <= '0;
         count_ff   <= '0;
         enabled_ff <= 1'b0;
         rearm_ff   <= 1'b0;
      end else if (strobe) begin
         if (chr_we) begin
            chr_bank_ff[slot] <= chr_bank_in;
         end
         latch_ff   <= latch_in;
         count_ff   <= count_in;
         enabled_ff <= enabled_in;
         rearm_ff   <= rearm_in;
      end
   end

endmodule

`default_nettype wire

>>> design/cartridge_bank_mapper_irq.sv
// -----------------------------------------------------------------------------
// Cartridge bank mapper with scanline IRQ
// Every request beat, bus write or scanline tick, yields exactly one response
// beat. A new request can be accepted in every cycle; the registers update
// in the cycle of acceptance, and the result sits in a response register
// backed by a one-entry skid register, so req_bus.ready drops only when both
// hold results the consumer has not taken.
// -----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper_irq (
   input  wire logic clock,
   input  wire logic reset,
   cbm_req_if.sink   req_bus,
   cbm_rsp_if.source rsp_bus
);
   import cbm_pkg::*;

   cbm_rsp_type result;
   cbm_rsp_type out_ff, out_in;
   cbm_rsp_type skid_ff, skid_in;
   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   logic        accept;
   logic        out_free;

   assign req_bus.ready = !skid_valid_ff;
   assign accept        = req_bus.valid && !skid_valid_ff;
   assign out_free      = !out_valid_ff || rsp_bus.ready;

   cbm_regs u_regs (
      .clock   (clock),
      .reset   (reset),
      .strobe  (accept),
      .command (req_bus.command),
      .address (req_bus.address),
      .value   (req_bus.value),
      .result  (result)
   );

   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            out_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_bus.valid      = out_valid_ff;
   assign rsp_bus.action     = out_ff.action;
   assign rsp_bus.prg_window = out_ff.prg_window;
   assign rsp_bus.prg_bank   = out_ff.prg_bank;
   assign rsp_bus.chr_slot   = out_ff.chr_slot;
   assign rsp_bus.chr_page   = out_ff.chr_page;
   assign rsp_bus.chr_is_ram = out_ff.chr_is_ram;
   assign rsp_bus.mirroring  = out_ff.mirroring;
   assign rsp_bus.irq_pulse  = out_ff.irq_pulse;

endmodule

`default_nettype wire

>>> design/cbm_checker.sv
// -----------------------------------------------------------------------------
// Mapper port checker
// Concurrent checks on the response channel of the bank mapper.
// -----------------------------------------------------------------------------
`default_nettype none

module cbm_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_action,
   input wire logic [11:0] rsp_chr_page,
   input wire logic        rsp_chr_is_ram,
   input wire logic        rsp_irq_pulse
);
   import cbm_pkg::*;

   // A stalled response beat must not disappear, and its action and character page must not change.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_chr_page)
                                 && $stable(rsp_action))
      else $error("stalled response beat changed");

   // No response is presented in the cycle after reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // An IRQ pulse only comes from a tick, which reports no mapping action.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_irq_pulse |-> rsp_action == ACT_NONE)
      else $error("IRQ pulse on a mapping beat");

   // The RAM select must follow the reported character page.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_chr_is_ram == (rsp_action == ACT_CHR &&
                    (rsp_chr_page == PAGE_RAM_LO || rsp_chr_page == PAGE_RAM_HI)))
      else $error("character RAM select does not match page");

endmodule

bind cartridge_bank_mapper_irq cbm_checker u_cbm_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_action     (rsp_bus.action),
   .rsp_chr_page   (rsp_bus.chr_page),
   .rsp_chr_is_ram (rsp_bus.chr_is_ram),
   .rsp_irq_pulse  (rsp_bus.irq_pulse)
);

`default_nettype wire

>>> tb/cartridge_bank_mapper_irq_test.sv
// -----------------------------------------------------------------------------
// Cartridge bank mapper testbench
// Drives bus writes and scanline ticks into the mapper through the request
// channel and predicts every response beat with an independent model of the
// character bank and IRQ counter registers. Directed tasks cover the decode
// corners and the counter overflow; a long random run follows, with random
// gaps on the request side and random stalls on the response side.
// -----------------------------------------------------------------------------
`default_nettype none

module cartridge_bank_mapper_irq_test;
   import cbm_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   logic clock;
   logic reset;

   cbm_req_if req_bus();
   cbm_rsp_if rsp_bus();

   cartridge_bank_mapper_irq u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   logic [7:0]  chr_regs [8];
   logic [7:0]  latch_value;
   logic [7:0]  count_value;
   logic        count_enabled;
   logic        count_rearm;
   cbm_rsp_type pending_events [$];

   int mismatches  = 0;
   int cycles      = 0;
   int items_sent  = 0;
   bit write_gaps  = 1'b0;
   bit read_stalls = 1'b0;
   int hold_left   = 0;
   int stall_left  = 0;

   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   function automatic cbm_rsp_type predict_event(input cbm_command_type cmd,
                                                 input logic [15:0] addr,
                                                 input logic [7:0] val);
      cbm_rsp_type ev;
      logic [3:0]  top;
      logic [15:0] dec;
      logic [2:0]  slot;
      logic [11:0] page;
      ev  = '0;
      top = addr[15:12];
      dec = addr & DEC_MASK;
      if (cmd == CMD_TICK) begin
         if (count_enabled) begin
            if (count_value == COUNT_MAX) begin
               count_value   = latch_value;
               ev.irq_pulse  = 1'b1;
               count_enabled = count_rearm;
            end else begin
               count_value = count_value + 8'd1;
            end
         end
      end else if (top == TOP_PRG_LOW || top == TOP_PRG_HIGH) begin
         ev.action     = ACT_PRG;
         ev.prg_window = (top == TOP_PRG_HIGH);
         ev.prg_bank   = val;
      end else if (dec == DEC_MIRROR) begin
         ev.action    = ACT_MIRROR;
         ev.mirroring = val[1:0];
      end else if (top >= TOP_CHR_FIRST && top <= TOP_CHR_LAST) begin
         slot = {2'(top - TOP_CHR_FIRST), addr[3]};
         if (!addr[2]) begin
            chr_regs[slot][3:0] = val[3:0];
            page = {4'h0, chr_regs[slot]};
         end else begin
            chr_regs[slot][7:4] = val[3:0];
            page = {4'h0, chr_regs[slot]} + {val[7:4], 8'h00};
         end
         ev.action     = ACT_CHR;
         ev.chr_slot   = slot;
         ev.chr_page   = page;
         ev.chr_is_ram = (page == PAGE_RAM_LO || page == PAGE_RAM_HI);
      end else begin
         case (dec)
            DEC_LATCH_LO: latch_value[3:0] = val[3:0];
            DEC_LATCH_HI: latch_value[7:4] = val[3:0];
            DEC_IRQ_CTRL: begin
               count_enabled = val[1];
               count_rearm   = val[0];
               count_value   = latch_value;
            end
            DEC_IRQ_ACK: count_enabled = count_rearm;
            default: ;
         endcase
      end
      return ev;
   endfunction

   task automatic send_item(input cbm_command_type cmd, input logic [15:0] addr,
                            input logic [7:0] val);
      if (write_gaps && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.command <= cmd;
      req_bus.address <= addr;
      req_bus.value   <= val;
      do @(posedge clock); while (!req_bus.ready);
      pending_events.push_back(predict_event(cmd, addr, val));
      items_sent++;
   endtask

   function automatic void compare_field(input string name, input int unsigned want,
                                         input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin : check_responses
      cbm_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_events.size() == 0) begin
            $error("response beat with no expected event");
            mismatches++;
         end else begin
            want = pending_events.pop_front();
            compare_field("action", 32'(want.action), 32'(rsp_bus.action));
            compare_field("prg_window", 32'(want.prg_window), 32'(rsp_bus.prg_window));
            compare_field("prg_bank", 32'(want.prg_bank), 32'(rsp_bus.prg_bank));
            compare_field("chr_slot", 32'(want.chr_slot), 32'(rsp_bus.chr_slot));
            compare_field("chr_page", 32'(want.chr_page), 32'(rsp_bus.chr_page));
            compare_field("chr_is_ram", 32'(want.chr_is_ram), 32'(rsp_bus.chr_is_ram));
            compare_field("mirroring", 32'(want.mirroring), 32'(rsp_bus.mirroring));
            compare_field("irq_pulse", 32'(want.irq_pulse), 32'(rsp_bus.irq_pulse));
         end
      end
   end

   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_bus.ready <= 1'b0;
         end else if (read_stalls && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic logic [15:0] irq_address(input logic [15:0] reg_dec);
      return reg_dec | {4'h0, 8'($urandom), 4'h0} | 16'($urandom_range(0, 3));
   endfunction

   task automatic test_program_banks();
      send_item(CMD_WRITE, 16'h8000, 8'h00);
      send_item(CMD_WRITE, 16'hAFFF, 8'hFF);
      send_item(CMD_WRITE, 16'h8ABC, 8'h5A);
   endtask

   task automatic test_mirroring();
      send_item(CMD_WRITE, 16'h9000, 8'hFC);
      send_item(CMD_WRITE, 16'h9FF3, 8'h01);
      send_item(CMD_WRITE, 16'h9123, 8'h03);
   endtask

   task automatic test_character_banks();
      send_item(CMD_WRITE, 16'hB000, 8'h04);
      send_item(CMD_WRITE, 16'hB004, 8'hF0);
      send_item(CMD_WRITE, 16'hC008, 8'h05);
      send_item(CMD_WRITE, 16'hE00C, 8'hFF);
      send_item(CMD_WRITE, 16'hD00C, 8'h0A);
   endtask

   task automatic test_irq_counter();
      send_item(CMD_WRITE, DEC_LATCH_LO, 8'h0E);
      send_item(CMD_WRITE, DEC_LATCH_HI, 8'hFF);
      send_item(CMD_WRITE, DEC_IRQ_CTRL, 8'h03);
      send_item(CMD_TICK, 16'hFFFF, 8'hFF);
      send_item(CMD_TICK, 16'h8000, 8'h00);
      send_item(CMD_TICK, 16'hF00C, 8'h55);
      send_item(CMD_WRITE, DEC_IRQ_CTRL, 8'h02);
      send_item(CMD_TICK, 16'h1234, 8'hAA);
      send_item(CMD_TICK, 16'h0000, 8'h00);
      send_item(CMD_TICK, 16'h0000, 8'h00);
      send_item(CMD_WRITE, DEC_IRQ_ACK, 8'hFF);
   endtask

   task automatic test_ignored_writes();
      send_item(CMD_WRITE, 16'h9004, 8'hFF);
      send_item(CMD_WRITE, 16'h9FFC, 8'h03);
      send_item(CMD_WRITE, 16'h7FFF, 8'hFF);
   endtask

   task automatic test_output_backpressure();
      int i;
      write_gaps = 1'b0;
      hold_left  = 60;
      for (i = 0; i < 12; i++)
         send_item(CMD_WRITE, {TOP_PRG_HIGH, 12'($urandom)}, 8'($urandom));
   endtask

   task automatic test_random_traffic(input int target);
      int start;
      int kind;
      int n;
      int i;
      logic [7:0] val;
      start = items_sent;
      while (items_sent - start < target) begin
         if (items_sent - start >= target - 150) begin
            write_gaps  = 1'b0;
            read_stalls = 1'b0;
         end else if ($urandom_range(0, 79) == 0) begin
            write_gaps  = 1'($urandom_range(0, 1));
            read_stalls = 1'($urandom_range(0, 1));
         end
         kind = $urandom_range(0, 99);
         if (kind < 10) begin
            send_item(CMD_WRITE, {($urandom_range(0, 1) ? TOP_PRG_HIGH : TOP_PRG_LOW),
                                  12'($urandom)}, 8'($urandom));
         end else if (kind < 18) begin
            send_item(CMD_WRITE, {4'h9, 8'($urandom), 2'b00, 2'($urandom)}, 8'($urandom));
         end else if (kind < 40) begin
            send_item(CMD_WRITE, {4'($urandom_range(TOP_CHR_FIRST, TOP_CHR_LAST)),
                                  12'($urandom)}, 8'($urandom));
         end else if (kind < 55) begin
            val = 8'($urandom);
            send_item(CMD_WRITE, irq_address(DEC_LATCH_LO), val);
            val = 8'($urandom);
            if ($urandom_range(0, 3) != 0)
               val[3:0] = 4'hF;
            send_item(CMD_WRITE, irq_address(DEC_LATCH_HI), val);
            val = 8'($urandom);
            if ($urandom_range(0, 3) != 0)
               val[1] = 1'b1;
            send_item(CMD_WRITE, irq_address(DEC_IRQ_CTRL), val);
            if ($urandom_range(0, 3) == 0)
               send_item(CMD_WRITE, irq_address(DEC_IRQ_ACK), 8'($urandom));
         end else if (kind < 95) begin
            n = $urandom_range(1, 8);
            for (i = 0; i < n; i++)
               send_item(CMD_TICK, 16'($urandom), 8'($urandom));
            if ($urandom_range(0, 5) == 0)
               send_item(CMD_WRITE, irq_address(DEC_IRQ_ACK), 8'($urandom));
         end else begin
            if ($urandom_range(0, 1) == 0)
               send_item(CMD_WRITE, 16'($urandom_range(0, 16'h7FFF)), 8'($urandom));
            else
               send_item(CMD_WRITE, {4'h9, 8'($urandom), 2'($urandom_range(1, 3)),
                                     2'($urandom)}, 8'($urandom));
         end
      end
   endtask

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_WRITE;
      req_bus.address = 16'h0000;
      req_bus.value   = 8'h00;
      for (int i = 0; i < 8; i++)
         chr_regs[i] = 8'h00;
      latch_value   = 8'h00;
      count_value   = 8'h00;
      count_enabled = 1'b0;
      count_rearm   = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      write_gaps  = 1'b1;
      read_stalls = 1'b1;
      test_program_banks();
      test_mirroring();
      test_character_banks();
      test_irq_counter();
      test_ignored_writes();
      test_output_backpressure();
      test_random_traffic(1100);
      req_bus.valid <= 1'b0;
      write_gaps  = 1'b0;
      read_stalls = 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> filelist.f
design/cbm_pkg.sv
design/cbm_req_if.sv
design/cbm_rsp_if.sv
design/cbm_regs.sv
design/cartridge_bank_mapper_irq.sv
design/cbm_checker.sv
tb/cartridge_bank_mapper_irq_test.sv
